/* rtl/bba_pkg.sv */
package bba_pkg;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NO_FIT  = 2'd1,
      STATUS_BAD_ADR = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DOWN_RD,
      ST_DOWN_EV,
      ST_UP_RD,
      ST_UP_EV,
      ST_FREE_RD,
      ST_FREE_EV,
      ST_MERGE_RD,
      ST_MERGE_EV,
      ST_DONE
   } state_type;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

endpackage

/* rtl/buddy_block_allocator.sv */
// Operation: allocate walks the tree depth first; each visited node takes a
// registered read of the mark memory, then an evaluate and write back, and on
// the way back up each parent is read and updated the same way; free walks
// down and merges up with a read and an evaluate per level. One item in flight at a time.
// Throughput: one item per walk; a new request is taken only when idle.
// Reset: synchronous; after reset a clearing pass over every slot empties
// the mark memory, during which no beat is accepted (csr writes still taken).
module buddy_block_allocator #(
   parameter int LEVELS    = 10,
   parameter int HEAP_LOG2 = 30
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // op[0], request_size[31:1], address[95:32]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [71:0]  rsp_tdata,   // status[1:0], block_address[65:2], zero fill
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [63:0]  csr_data
);
   localparam int USED = (LEVELS < HEAP_LOG2 + 1) ? LEVELS : HEAP_LOG2 + 1;
   localparam int NW   = LEVELS;                 // node index width
   localparam int DW   = $clog2(LEVELS + 1);
   localparam int SLOT = 1 << LEVELS;

   // node marks: bit1 split-or-used, bit0 allocated
   logic [1:0] mem [SLOT];
   logic [1:0] rd_q;
   logic [NW-1:0] rd_adr, wr_adr;
   logic [1:0]    wr_dat;
   logic          wr_en;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_adr] <= wr_dat;
      end
      rd_q <= mem[rd_adr];
   end

   bba_pkg::state_type state_ff, state_in;
   logic [NW-1:0]  node_ff, node_in;
   logic [DW-1:0]  dep_ff, dep_in;
   logic [30:0]    size_ff, size_in;
   logic [40:0]    off_ff, off_in;     // heap offset being freed
   logic [63:0]    base_ff, base_in;
   logic [1:0]     stat_ff, stat_in;
   logic [63:0]    badr_ff, badr_in;
   logic           up_ok_ff, up_ok_in; // ascending after child success
   logic [NW:0]    clr_ff, clr_in;

   logic [40:0] nsize, half, found_off;
   logic        leaf, fits, take;
   logic [64:0] diff;

   always_comb begin
      nsize = 41'd1 << (HEAP_LOG2 - int'(dep_ff));
      half  = nsize >> 1;
      leaf  = (int'(dep_ff) + 1 >= USED);
      fits  = ({10'd0, size_ff} <= nsize);
      take  = !rd_q[1] && (leaf || ({10'd0, size_ff} > half));
      // offset of a node from its index and depth
      found_off = 41'(({{(41-NW){1'b0}}, node_ff} - (41'd1 << dep_ff))
                  << (HEAP_LOG2 - int'(dep_ff)));
      diff = {1'b0, req_tdata[95:32]} - {1'b0, base_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bba_pkg::ST_CLEAR;
         clr_ff   <= '0;
         base_ff  <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         base_ff  <= base_in;
      end
      node_ff  <= node_in;
      dep_ff   <= dep_in;
      size_ff  <= size_in;
      off_ff   <= off_in;
      stat_ff  <= stat_in;
      badr_ff  <= badr_in;
      up_ok_ff <= up_ok_in;
   end

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == bba_pkg::ST_IDLE);
   assign rsp_tvalid = (state_ff == bba_pkg::ST_DONE);
   assign rsp_tdata  = {6'd0, badr_ff, stat_ff};

   always_comb begin
      state_in = state_ff;
      node_in  = node_ff;
      dep_in   = dep_ff;
      size_in  = size_ff;
      off_in   = off_ff;
      stat_in  = stat_ff;
      badr_in  = badr_ff;
      up_ok_in = up_ok_ff;
      clr_in   = clr_ff;
      base_in  = (csr_valid) ? csr_data : base_ff;
      rd_adr   = node_ff;
      wr_adr   = node_ff;
      wr_dat   = 2'b00;
      wr_en    = 1'b0;
      unique case (state_ff)
         bba_pkg::ST_CLEAR: begin
            // sweep the mark memory
            wr_en  = 1'b1;
            wr_adr = clr_ff[NW-1:0];
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (NW+1)'(SLOT - 1)) begin
               state_in = bba_pkg::ST_IDLE;
            end
         end
         bba_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               size_in = (req_tdata[31:1] == '0) ? 31'd1 : req_tdata[31:1];
               node_in = NW'(1);
               dep_in  = '0;
               badr_in = '0;
               stat_in = bba_pkg::STATUS_OK;
               if (req_tdata[0] == bba_pkg::OP_ALLOC) begin
                  state_in = bba_pkg::ST_DOWN_RD;
               end else if (diff[64] || (diff[63:0] >> HEAP_LOG2) != 64'd0) begin
                  stat_in  = bba_pkg::STATUS_BAD_ADR;
                  state_in = bba_pkg::ST_DONE;
               end else begin
                  off_in   = 41'(diff[63:0]);
                  state_in = bba_pkg::ST_FREE_RD;
               end
            end
         end
         bba_pkg::ST_DOWN_RD: state_in = bba_pkg::ST_DOWN_EV;
         bba_pkg::ST_DOWN_EV: begin
            // visit node: take it, descend left, or fail upward
            if (!fits || rd_q[0] || (leaf && !take)) begin
               up_ok_in = 1'b0;
               state_in = bba_pkg::ST_UP_RD;
            end else if (take) begin
               wr_en    = 1'b1;
               wr_dat   = 2'b11;
               badr_in  = base_ff + 64'(found_off);
               up_ok_in = 1'b1;
               state_in = bba_pkg::ST_UP_RD;
            end else begin
               node_in  = node_ff << 1;
               dep_in   = dep_ff + 1'b1;
               state_in = bba_pkg::ST_DOWN_RD;
            end
         end
         bba_pkg::ST_UP_RD: begin
            // finish at the root; after a failed left child try its sibling, else climb
            if (node_ff == NW'(1)) begin
               if (!up_ok_ff) begin
                  stat_in = bba_pkg::STATUS_NO_FIT;
               end
               state_in = bba_pkg::ST_DONE;
            end else if (!up_ok_ff && !node_ff[0]) begin
               node_in  = node_ff | NW'(1);
               state_in = bba_pkg::ST_DOWN_RD;
            end else begin
               rd_adr   = node_ff >> 1;
               node_in  = node_ff >> 1;
               dep_in   = dep_ff - 1'b1;
               state_in = bba_pkg::ST_UP_EV;
            end
         end
         bba_pkg::ST_UP_EV: begin
            // parent read done; mark split on success path
            if (up_ok_ff) begin
               wr_en  = 1'b1;
               wr_dat = {1'b1, rd_q[0]};
            end
            state_in = bba_pkg::ST_UP_RD;
         end
         bba_pkg::ST_FREE_RD: state_in = bba_pkg::ST_FREE_EV;
         bba_pkg::ST_FREE_EV: begin
            if (rd_q[0]) begin
               wr_en    = 1'b1;
               state_in = bba_pkg::ST_MERGE_RD;
            end else if (leaf || !rd_q[1]) begin
               stat_in  = bba_pkg::STATUS_BAD_ADR;
               state_in = bba_pkg::ST_DONE;
            end else begin
               node_in  = (node_ff << 1) |
                          NW'(off_ff[HEAP_LOG2 - 1 - int'(dep_ff)]);
               dep_in   = dep_ff + 1'b1;
               state_in = bba_pkg::ST_FREE_RD;
            end
         end
         bba_pkg::ST_MERGE_RD: begin
            rd_adr = node_ff ^ NW'(1);
            if (node_ff == NW'(1)) begin
               state_in = bba_pkg::ST_DONE;
            end else begin
               state_in = bba_pkg::ST_MERGE_EV;
            end
         end
         bba_pkg::ST_MERGE_EV: begin
            // buddy wholly free: clear parent and climb
            if (rd_q != 2'b00) begin
               state_in = bba_pkg::ST_DONE;
            end else begin
               wr_en    = 1'b1;
               wr_adr   = node_ff >> 1;
               node_in  = node_ff >> 1;
               state_in = bba_pkg::ST_MERGE_RD;
            end
         end
         bba_pkg::ST_DONE: begin
            if (rsp_tready) begin
               state_in = bba_pkg::ST_IDLE;
            end
         end
         default: state_in = bba_pkg::ST_IDLE;
      endcase
   end

endmodule
